@@ hdl/integer_alu_with_word_ops_unit_assert.svh @@
// Assertion macros for the integer ALU with word operations.
`ifndef INTEGER_ALU_WITH_WORD_OPS_UNIT_ASSERT_SVH
`define INTEGER_ALU_WITH_WORD_OPS_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IALU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IALU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ialu_pkg.sv @@
// Package for the integer ALU: operation, width and convert codes and helpers.
package ialu_pkg;

  localparam int unsigned XLEN     = 64;
  localparam int unsigned OP_W     = 5;
  localparam int unsigned WIDTH_W  = 2;
  localparam int unsigned CVT_W    = 3;
  localparam int unsigned IMM_SIGN = 11;
  localparam int unsigned IMM_BITS = 12;

  typedef logic [XLEN-1:0] xword_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_AND  = 5'd2,
    OP_ANDI = 5'd3,
    OP_OR   = 5'd4,
    OP_XOR  = 5'd5,
    OP_SLL  = 5'd6,
    OP_SRL  = 5'd7,
    OP_SRA  = 5'd8,
    OP_ADDW = 5'd9,
    OP_SUBW = 5'd10,
    OP_ANDW = 5'd11,
    OP_ORW  = 5'd12,
    OP_XORW = 5'd13,
    OP_SLLW = 5'd14,
    OP_SRLW = 5'd15,
    OP_SRAW = 5'd16
  } op_t;

  typedef enum logic [WIDTH_W-1:0] {
    WID_D = 2'd0,
    WID_W = 2'd1,
    WID_H = 2'd2,
    WID_B = 2'd3
  } width_t;

  typedef enum logic [CVT_W-1:0] {
    CVT_NONE = 3'd0,
    CVT_U32  = 3'd1,
    CVT_S32  = 3'd2,
    CVT_S16  = 3'd3,
    CVT_U16  = 3'd4,
    CVT_S8   = 3'd5,
    CVT_U8   = 3'd6
  } cvt_t;

  // Sign-extend the low word to the full register width.
  function automatic xword_t sext32(input xword_t v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

endpackage

@@ hdl/integer_alu_with_word_ops_unit.sv @@
// Integer ALU with word operations: top level, one registered pass per transaction.
//
// Two-stage 64-bit integer ALU. An input transaction is captured in the
// operand register; the whole operation (three-input add, sub, logic
// ops, andi with a 12-bit immediate whose upper bits are forced to one
// when bit 11 is set, sized shifts and the 32-bit word forms) is then
// computed in one combinational pass and written into the result register
// once that register is free. out_valid is registered in the result
// stage, and the unit sustains one transaction per cycle while out_ready
// is high: the operand register refills whenever its contents move into
// the result register, and the result register can be reloaded in the same
// cycle its transaction is taken. When out_ready is held low both registers
// fill and in_ready drops; the deepest path is the 64-bit three-input add
// or the 64-bit barrel shift, followed by the result select.
// Unused operation codes 17 to 31 return zero; three_input is ignored for
// everything but add and addw.
`include "integer_alu_with_word_ops_unit_assert.svh"

module integer_alu_with_word_ops_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ialu_pkg::OP_W-1:0]          in_operation,
  input  logic [ialu_pkg::XLEN-1:0]          in_src_a,
  input  logic [ialu_pkg::XLEN-1:0]          in_src_b,
  input  logic [ialu_pkg::XLEN-1:0]          in_src_c,
  input  logic                               in_three_input,
  input  logic [ialu_pkg::WIDTH_W-1:0]       in_src_a_width,
  input  logic [ialu_pkg::CVT_W-1:0]         in_src_a_convert,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ialu_pkg::XLEN-1:0]          out_result
);
  import ialu_pkg::*;

  // Operand register (stage 1)
  logic                 s1_valid_r, s1_valid_nxt;
  logic [OP_W-1:0]      s1_op_r;
  xword_t               s1_a_r, s1_b_r, s1_c_r;
  logic                 s1_three_r;
  logic [WIDTH_W-1:0]   s1_width_r;
  logic [CVT_W-1:0]     s1_cvt_r;

  // Result register (stage 2)
  logic                 out_valid_r, out_valid_nxt;
  xword_t               out_result_r, result_nxt;

  logic out_free;   // result register can take a new value this cycle
  logic s1_move;    // operand register hands its transaction forward
  logic in_take;    // input transaction accepted

  assign out_free = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_take  = in_valid && in_ready;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_move);
  assign out_valid_nxt = s1_move || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture operands on acceptance; payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r    <= in_operation;
      s1_a_r     <= in_src_a;
      s1_b_r     <= in_src_b;
      s1_c_r     <= in_src_c;
      s1_three_r <= in_three_input;
      s1_width_r <= in_src_a_width;
      s1_cvt_r   <= in_src_a_convert;
    end
  end

  // ---------------------------------------------------------------------
  // Single combinational pass
  // ---------------------------------------------------------------------
  logic [5:0] sh6;
  logic [4:0] sh5;
  xword_t     sum, diff, and_v, or_v, xor_v, andi_imm;
  xword_t     srl_src, sra_src, srl_v, sra_v, sll_v;
  logic       sra_arith;
  logic [31:0] w_sll, w_srl, w_sra;

  assign sh6 = s1_b_r[5:0];
  assign sh5 = s1_b_r[4:0];

  // Three-input add: third addend gated by the flag.
  assign sum   = s1_a_r + s1_b_r + (s1_three_r ? s1_c_r : '0);
  assign diff  = s1_a_r - s1_b_r;
  assign and_v = s1_a_r & s1_b_r;
  assign or_v  = s1_a_r | s1_b_r;
  assign xor_v = s1_a_r ^ s1_b_r;

  // andi: force upper bits to one when the immediate sign bit is set.
  assign andi_imm = s1_b_r[IMM_SIGN] ?
                    {{(XLEN-IMM_BITS){1'b1}}, s1_b_r[IMM_BITS-1:0]} : s1_b_r;

  assign sll_v = s1_a_r << sh6;

  // srl: mask the source to its width first.
  always_comb begin
    case (s1_width_r)
      WID_W:   srl_src = {32'd0, s1_a_r[31:0]};
      WID_H:   srl_src = {48'd0, s1_a_r[15:0]};
      WID_B:   srl_src = {56'd0, s1_a_r[7:0]};
      default: srl_src = s1_a_r;
    endcase
  end
  assign srl_v = srl_src >> sh6;

  // sra: signed converts sign-extend then shift arithmetically; unsigned
  // converts shift the full source logically.
  always_comb begin
    case (s1_cvt_r)
      CVT_U32, CVT_U16, CVT_U8: begin
        sra_src   = s1_a_r;
        sra_arith = 1'b0;
      end
      CVT_S32: begin
        sra_src   = sext32(s1_a_r);
        sra_arith = 1'b1;
      end
      CVT_S16: begin
        sra_src   = {{48{s1_a_r[15]}}, s1_a_r[15:0]};
        sra_arith = 1'b1;
      end
      CVT_S8: begin
        sra_src   = {{56{s1_a_r[7]}}, s1_a_r[7:0]};
        sra_arith = 1'b1;
      end
      default: begin
        sra_src   = s1_a_r;
        sra_arith = 1'b1;
      end
    endcase
  end
  assign sra_v = sra_arith ? xword_t'($signed(sra_src) >>> sh6) : (sra_src >> sh6);

  // Word shifts operate on the low 32 bits.
  assign w_sll = s1_a_r[31:0] << sh5;
  assign w_srl = s1_a_r[31:0] >> sh5;
  assign w_sra = 32'($signed(s1_a_r[31:0]) >>> sh5);

  always_comb begin
    case (s1_op_r)
      OP_ADD:  result_nxt = sum;
      OP_SUB:  result_nxt = diff;
      OP_AND:  result_nxt = and_v;
      OP_ANDI: result_nxt = s1_a_r & andi_imm;
      OP_OR:   result_nxt = or_v;
      OP_XOR:  result_nxt = xor_v;
      OP_SLL:  result_nxt = sll_v;
      OP_SRL:  result_nxt = srl_v;
      OP_SRA:  result_nxt = sra_v;
      OP_ADDW: result_nxt = sext32(sum);
      OP_SUBW: result_nxt = sext32(diff);
      OP_ANDW: result_nxt = sext32(and_v);
      OP_ORW:  result_nxt = sext32(or_v);
      OP_XORW: result_nxt = sext32(xor_v);
      OP_SLLW: result_nxt = sext32({32'd0, w_sll});
      OP_SRLW: result_nxt = sext32({32'd0, w_srl});
      OP_SRAW: result_nxt = sext32({32'd0, w_sra});
      default: result_nxt = '0;
    endcase
  end

  // Load the result register whenever stage 1 advances.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_result_r <= result_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `IALU_ASSERT_NEXT(a_advance_fills_out, s1_move, out_valid_r, "advance lost result")
  `IALU_ASSERT_NEXT(a_stall_holds_s1, s1_valid_r && out_valid_r && !out_ready, s1_valid_r, "operand dropped under stall")
  `IALU_ASSERT_NOW(a_ready_needs_room, in_ready && s1_valid_r, out_free, "ready without room downstream")

endmodule

@@ tb/sv/tb_integer_alu_with_word_ops_unit.sv @@
// Self-checking testbench for the 64-bit integer ALU with word operations.
module tb_integer_alu_with_word_ops_unit;
  import ialu_pkg::*;

  // Codes outside the named operation and convert sets; the block must still
  // treat them as defined: spare operations return zero, the spare convert
  // code behaves like a plain 64-bit arithmetic shift.
  localparam logic [OP_W-1:0]  OP_FIRST_SPARE = 5'd17;
  localparam logic [OP_W-1:0]  OP_LAST_SPARE  = 5'd31;
  localparam logic [CVT_W-1:0] CVT_SPARE      = 3'd7;
  localparam xword_t           ALL_ONES       = {XLEN{1'b1}};
  localparam int unsigned      RANDOM_ITEMS   = 750;
  // Receiver hold-off: starts once this many results have been checked.
  localparam int unsigned      HOLD_AT_RESULT = 300;
  localparam int unsigned      HOLD_CYCLES    = 80;

  // One input transaction. When known is set, result holds the value read
  // straight off the operation; otherwise the predictor supplies it.
  typedef struct {
    logic [OP_W-1:0]    op;
    xword_t             src_a;
    xword_t             src_b;
    xword_t             src_c;
    logic               three;
    logic [WIDTH_W-1:0] width;
    logic [CVT_W-1:0]   cvt;
    logic               known;
    xword_t             result;
  } alu_item_t;

  typedef struct {
    int unsigned     seq;
    logic [OP_W-1:0] op;
    xword_t          value;
  } alu_expect_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    in_operation = '0;
  xword_t             in_src_a = '0;
  xword_t             in_src_b = '0;
  xword_t             in_src_c = '0;
  logic               in_three_input = 1'b0;
  logic [WIDTH_W-1:0] in_src_a_width = '0;
  logic [CVT_W-1:0]   in_src_a_convert = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  xword_t             out_result;

  alu_expect_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned items_accepted = 0;
  // Set by the sender for a stretch of items: both sides then run without gaps.
  bit          steady_flow = 1'b0;

  // Directed transactions: extremes, every operation but andw, orw and xorw, and the corner cases.
  alu_item_t directed_rows [25] = '{
    '{OP_ADD,  64'h0, 64'h0, 64'h0, 1'b0, WID_D, CVT_NONE, 1'b1, 64'h0},
    '{OP_ADD,  ALL_ONES, 64'h1, 64'h0, 1'b0, WID_D, CVT_NONE, 1'b1, 64'h0},
    '{OP_ADD,  ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, WID_D, CVT_NONE, 1'b1,
      64'hFFFF_FFFF_FFFF_FFFD},
    '{OP_SUB,  64'h0, 64'h1, 64'h0, 1'b0, WID_D, CVT_NONE, 1'b1, ALL_ONES},
    '{OP_AND,  64'hF0F0_1234_5678_9ABC, 64'h0FF0_FFFF_0000_FFFF, 64'h0, 1'b1,
      WID_D, CVT_NONE, 1'b0, 64'h0},
    '{OP_ANDI, ALL_ONES, 64'h800, 64'h0, 1'b0, WID_D, CVT_NONE, 1'b1,
      64'hFFFF_FFFF_FFFF_F800},
    '{OP_ANDI, ALL_ONES, 64'hFFFF_0000_0000_07FF, 64'h0, 1'b0, WID_D, CVT_NONE,
      1'b1, 64'hFFFF_0000_0000_07FF},
    '{OP_OR,   64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000, 64'h0, 1'b0,
      WID_D, CVT_NONE, 1'b0, 64'h0},
    '{OP_XOR,  ALL_ONES, 64'h5555_AAAA_5555_AAAA, 64'h0, 1'b0, WID_D, CVT_NONE,
      1'b0, 64'h0},
    '{OP_SLL,  64'h1, 64'd63, 64'h0, 1'b0, WID_D, CVT_NONE, 1'b1,
      64'h8000_0000_0000_0000},
    '{OP_SRL,  ALL_ONES, 64'd63, 64'h0, 1'b0, WID_D, CVT_NONE, 1'b1, 64'h1},
    '{OP_SRL,  ALL_ONES, 64'd0, 64'h0, 1'b0, WID_W, CVT_NONE, 1'b1,
      64'hFFFF_FFFF},
    '{OP_SRL,  ALL_ONES, 64'd4, 64'h0, 1'b0, WID_H, CVT_NONE, 1'b1, 64'hFFF},
    '{OP_SRL,  ALL_ONES, 64'd7, 64'h0, 1'b0, WID_B, CVT_NONE, 1'b1, 64'h1},
    '{OP_SRA,  64'h8000_0000_0000_0000, 64'd63, 64'h0, 1'b0, WID_D, CVT_NONE,
      1'b1, ALL_ONES},
    '{OP_SRA,  64'h8000_0000, 64'd40, 64'h0, 1'b0, WID_D, CVT_S32, 1'b1, ALL_ONES},
    '{OP_SRA,  64'h8000, 64'd16, 64'h0, 1'b0, WID_D, CVT_S16, 1'b1, ALL_ONES},
    '{OP_SRA,  64'h80, 64'd3, 64'h0, 1'b0, WID_D, CVT_S8, 1'b1,
      64'hFFFF_FFFF_FFFF_FFF0},
    '{OP_SRA,  ALL_ONES, 64'd60, 64'h0, 1'b0, WID_D, CVT_U32, 1'b1, 64'hF},
    '{OP_ADDW, 64'h7FFF_FFFF, 64'h1, 64'h0, 1'b0, WID_D, CVT_NONE, 1'b1,
      64'hFFFF_FFFF_8000_0000},
    '{OP_SUBW, 64'h0, 64'h1, ALL_ONES, 1'b1, WID_D, CVT_NONE, 1'b0, 64'h0},
    '{OP_SLLW, 64'h1, 64'd31, 64'h0, 1'b0, WID_D, CVT_NONE, 1'b1,
      64'hFFFF_FFFF_8000_0000},
    '{OP_SRLW, 64'hFFFF_FFFF_8000_0000, 64'd31, 64'h0, 1'b0, WID_D, CVT_NONE,
      1'b1, 64'h1},
    '{OP_SRAW, 64'h8000_0000, 64'd31, 64'h0, 1'b0, WID_D, CVT_NONE, 1'b1, ALL_ONES},
    '{OP_LAST_SPARE, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, WID_B, CVT_SPARE, 1'b1,
      64'h0}
  };

  integer_alu_with_word_ops_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_src_a         (in_src_a),
    .in_src_b         (in_src_b),
    .in_src_c         (in_src_c),
    .in_three_input   (in_three_input),
    .in_src_a_width   (in_src_a_width),
    .in_src_a_convert (in_src_a_convert),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result       (out_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Widen a 32-bit value to the register width, copying bit 31 upward.
  function automatic xword_t word_to_xlen(input logic [31:0] w);
    return {{32{w[31]}}, w};
  endfunction

  // Compute the ALU result for one transaction.
  function automatic xword_t alu_compute(input alu_item_t it);
    xword_t     sum;
    xword_t     imm;
    xword_t     masked;
    logic [5:0] sh6;
    logic [4:0] sh5;
    sh6 = it.src_b[5:0];
    sh5 = it.src_b[4:0];
    sum = it.src_a + it.src_b + (it.three ? it.src_c : '0);
    case (it.op)
      OP_ADD:  return sum;
      OP_SUB:  return it.src_a - it.src_b;
      OP_AND:  return it.src_a & it.src_b;
      OP_ANDI: begin
        // When bit 11 of the immediate is set, it fills everything above it.
        imm = it.src_b;
        if (it.src_b[IMM_SIGN]) imm[XLEN-1:IMM_BITS] = '1;
        return it.src_a & imm;
      end
      OP_OR:   return it.src_a | it.src_b;
      OP_XOR:  return it.src_a ^ it.src_b;
      OP_SLL:  return it.src_a << sh6;
      OP_SRL: begin
        case (it.width)
          WID_W:   masked = {32'h0, it.src_a[31:0]};
          WID_H:   masked = {48'h0, it.src_a[15:0]};
          WID_B:   masked = {56'h0, it.src_a[7:0]};
          default: masked = it.src_a;
        endcase
        return masked >> sh6;
      end
      OP_SRA: begin
        // Unsigned converts shift the whole source logically, signed ones
        // sign-extend the low part first; none and the spare code use all 64 bits.
        case (it.cvt)
          CVT_U32, CVT_U16, CVT_U8: return it.src_a >> sh6;
          CVT_S32: masked = word_to_xlen(it.src_a[31:0]);
          CVT_S16: masked = {{48{it.src_a[15]}}, it.src_a[15:0]};
          CVT_S8:  masked = {{56{it.src_a[7]}}, it.src_a[7:0]};
          default: masked = it.src_a;
        endcase
        return $signed(masked) >>> sh6;
      end
      OP_ADDW: return word_to_xlen(sum[31:0]);
      OP_SUBW: begin
        masked = it.src_a - it.src_b;
        return word_to_xlen(masked[31:0]);
      end
      OP_ANDW: return word_to_xlen(it.src_a[31:0] & it.src_b[31:0]);
      OP_ORW:  return word_to_xlen(it.src_a[31:0] | it.src_b[31:0]);
      OP_XORW: return word_to_xlen(it.src_a[31:0] ^ it.src_b[31:0]);
      OP_SLLW: return word_to_xlen(it.src_a[31:0] << sh5);
      OP_SRLW: return word_to_xlen(it.src_a[31:0] >> sh5);
      OP_SRAW: return $signed(word_to_xlen(it.src_a[31:0])) >>> sh5;
      default: return '0;
    endcase
  endfunction

  // Operand values weighted toward the edges of the 64-bit and 32-bit ranges.
  function automatic xword_t pick_operand();
    xword_t v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = ALL_ONES;
      2: v = xword_t'(1) << $urandom_range(0, 63);
      3: v = {32'h0, $urandom()};
      4: v = word_to_xlen($urandom());
      5: v = xword_t'($urandom_range(0, 70));
      default: v = {$urandom(), $urandom()};
    endcase
    return v;
  endfunction

  function automatic alu_item_t make_random_item();
    alu_item_t it;
    // Mostly defined operations; a few spare codes to check the zero result.
    if ($urandom_range(0, 99) < 4)
      it.op = OP_W'($urandom_range(int'(OP_FIRST_SPARE), int'(OP_LAST_SPARE)));
    else
      it.op = OP_W'($urandom_range(int'(OP_ADD), int'(OP_SRAW)));
    it.src_a = pick_operand();
    it.src_b = pick_operand();
    it.src_c = pick_operand();
    it.three = 1'($urandom_range(0, 1));
    it.width = WIDTH_W'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 5) it.cvt = CVT_SPARE;
    else it.cvt = CVT_W'($urandom_range(int'(CVT_NONE), int'(CVT_U8)));
    it.known = 1'b0;
    it.result = '0;
    return it;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  // Offer one transaction and hold it until the block takes it; record the
  // expected result at the accepting edge.
  task automatic send_item(input alu_item_t it);
    int unsigned gap;
    alu_expect_t e;
    gap = 0;
    if (!steady_flow) begin
      while (gap < 8 && $urandom_range(0, 99) < 17) gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= it.op;
    in_src_a         <= it.src_a;
    in_src_b         <= it.src_b;
    in_src_c         <= it.src_c;
    in_three_input   <= it.three;
    in_src_a_width   <= it.width;
    in_src_a_convert <= it.cvt;
    do @(posedge clk); while (!in_ready);
    e.seq   = items_accepted;
    e.op    = it.op;
    e.value = it.known ? it.result : alu_compute(it);
    pending_results.push_back(e);
    items_accepted++;
  endtask

  // Result side: check each transaction taken, then choose the next ready.
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    alu_expect_t e;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %h with no transaction pending",
                                    out_result));
        end else begin
          e = pending_results.pop_front();
          if (out_result !== e.value)
            report_mismatch($sformatf("item %0d op %0d: result %h, expected %h",
                                      e.seq, e.op, out_result, e.value));
        end
        results_checked++;
      end
      // Hold off once for a long stretch so the block fills and drops in_ready.
      if (!hold_done && results_checked >= HOLD_AT_RESULT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady_flow || ($urandom_range(0, 99) >= 17);
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    alu_item_t it;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) send_item(directed_rows[i]);
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // Keep a stretch free of gaps on both sides; the hold-off lands in it.
      steady_flow = (n >= 230 && n < 400);
      it = make_random_item();
      send_item(it);
    end
    steady_flow = 1'b0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Drain: catch any stray result after the last expected one.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of about 800 transactions.
  initial begin : watchdog
    #(20 * 200000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/ialu_pkg.sv
hdl/integer_alu_with_word_ops_unit.sv
tb/sv/tb_integer_alu_with_word_ops_unit.sv
